// ===== src/bbr_pkg.sv =====
package bbr_pkg;

  // buffer geometry
  localparam int unsigned MAX_BLOCK = 64;
  localparam int unsigned ADDR_W    = $clog2(MAX_BLOCK);
  localparam int unsigned CNT_W     = $clog2(MAX_BLOCK + 1);

  // register map
  localparam int unsigned PADDR_W   = 3;
  localparam logic        REG_BLOCK_SIZE    = 1'b0;
  localparam logic        REG_WHOLE_MESSAGE = 1'b1;

  localparam logic [6:0]  BLOCK_SIZE_RESET = 7'd8;
  localparam logic [7:0]  PAD_BYTE         = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_REV
  } bbr_state_e;

endpackage

// ===== src/block_byte_reverser_top.sv =====
// a padded run starts in ST_PAD, else ST_REV redoes the stale read of the accept edge first
// throughput: one result per cycle while a run drains and out_ready_i stays high; input
//   is held off until the run ends, and bytes that start no run are accepted back to back
// reset (rst_ni low, async): block_size 8, whole_message 0, buffer empty, no drop seen,
//   output register empty; the byte memory itself is not cleared
module block_byte_reverser_top
  import bbr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // apb-style configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input stream
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               message_last_i,
  // result stream
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               run_last_o,
  output logic               message_done_o,
  output logic               truncated_o
);

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [6:0] block_size_q;
  logic       whole_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BLOCK_SIZE_RESET;
      whole_q      <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_BLOCK_SIZE: begin
          // sizes of zero or above MAX_BLOCK in pwdata[6:0] are ignored
          if (pwdata[6:0] != 7'd0 && pwdata[6:0] <= CNT_W'(MAX_BLOCK)) begin
            block_size_q <= pwdata[6:0];
          end
        end
        REG_WHOLE_MESSAGE: whole_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_SIZE:    prdata = {25'd0, block_size_q};
      REG_WHOLE_MESSAGE: prdata = {31'd0, whole_q};
      default:           prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // control state
  // ------------------------------------------------------------------
  bbr_state_e         state_q, state_d;
  logic [CNT_W-1:0]   fill_q, fill_d;       // bytes held in the memory
  logic               dropped_q, dropped_d; // a byte of this message was lost
  logic [CNT_W-1:0]   pad_q, pad_d;         // zero bytes still to send
  logic [CNT_W-1:0]   cnt_q, cnt_d;         // stored bytes still to send
  logic [ADDR_W-1:0]  idx_q, idx_d;         // memory entry of the next stored byte
  logic               last_q, last_d;       // run closes the message
  logic               trunc_q, trunc_d;     // run reports a truncation
  logic               rd_ok_q, rd_ok_d;     // rd_data_q holds entry idx_q

  logic               in_fire;
  logic               has_room;
  logic [CNT_W-1:0]   fill_inc;
  logic               drop_now;
  logic               emit_run;
  logic [CNT_W-1:0]   pad_amt;
  logic               out_free;
  logic               load_pad;
  logic               load_rev;

  // memory, one write and one read port, registered read data
  logic [7:0]         byte_store_q [MAX_BLOCK];
  logic [7:0]         rd_data_q;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               run_last_q, run_last_d;
  logic               done_q, done_d;
  logic               out_trunc_q, out_trunc_d;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;

  // effect of the incoming byte on the buffer
  assign has_room = (fill_q < CNT_W'(MAX_BLOCK));
  assign fill_inc = has_room ? fill_q + CNT_W'(1) : fill_q;
  assign drop_now = dropped_q | ~has_room;

  // does this transaction start a run, and with how much padding
  always_comb begin
    emit_run = 1'b0;
    pad_amt  = '0;
    if (whole_q) begin
      emit_run = message_last_i;
    end else if (fill_inc >= block_size_q) begin
      emit_run = 1'b1;
    end else if (message_last_i) begin
      emit_run = 1'b1;
      pad_amt  = block_size_q - fill_inc;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && emit_run) begin
          state_d = (pad_amt != '0) ? ST_PAD : ST_REV;
        end
      end
      ST_PAD: begin
        if (out_free && pad_q == CNT_W'(1)) begin
          state_d = ST_REV;
        end
      end
      ST_REV: begin
        if (out_free && rd_ok_q && cnt_q == CNT_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and output register control
  always_comb begin
    fill_d      = fill_q;
    dropped_d   = dropped_q;
    pad_d       = pad_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    last_d      = last_q;
    trunc_d     = trunc_q;
    load_pad    = 1'b0;
    load_rev    = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_byte_d  = out_byte_q;
    run_last_d  = run_last_q;
    done_d      = done_q;
    out_trunc_d = out_trunc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          pad_d   = pad_amt;
          cnt_d   = fill_inc;
          idx_d   = ADDR_W'(fill_inc - CNT_W'(1));
          last_d  = message_last_i;
          trunc_d = message_last_i & drop_now;
          if (message_last_i) begin
            fill_d    = '0;
            dropped_d = 1'b0;
          end else begin
            fill_d    = (emit_run && !whole_q) ? '0 : fill_inc;
            dropped_d = drop_now;
          end
        end
      end
      ST_PAD: begin
        load_pad = out_free;
      end
      ST_REV: begin
        load_rev = out_free & rd_ok_q;
      end
      default: ;
    endcase

    if (load_pad) begin
      pad_d       = pad_q - CNT_W'(1);
      out_valid_d = 1'b1;
      out_byte_d  = PAD_BYTE;
      run_last_d  = 1'b0;
      done_d      = 1'b0;
      out_trunc_d = trunc_q;
    end

    if (load_rev) begin
      cnt_d       = cnt_q - CNT_W'(1);
      idx_d       = idx_q - ADDR_W'(1);
      out_valid_d = 1'b1;
      out_byte_d  = rd_data_q;
      run_last_d  = (cnt_q == CNT_W'(1));
      done_d      = (cnt_q == CNT_W'(1)) & last_q;
      out_trunc_d = trunc_q;
    end
  end

  // the accept edge writes the entry that is read next, so the read
  // issued in that cycle is stale and gets thrown away
  assign rd_ok_d = ~in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      dropped_q   <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      dropped_q   <= dropped_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pad_q       <= pad_d;
    cnt_q       <= cnt_d;
    idx_q       <= idx_d;
    last_q      <= last_d;
    trunc_q     <= trunc_d;
    out_byte_q  <= out_byte_d;
    run_last_q  <= run_last_d;
    done_q      <= done_d;
    out_trunc_q <= out_trunc_d;
  end

  // byte memory: write at the fill position, read ahead at the next index
  always_ff @(posedge clk_i) begin
    if (in_fire && has_room) begin
      byte_store_q[fill_q[ADDR_W-1:0]] <= in_byte_i;
    end
    rd_data_q <= byte_store_q[idx_d];
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign run_last_o     = run_last_q;
  assign message_done_o = done_q;
  assign truncated_o    = out_trunc_q;

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(MAX_BLOCK))
    else $error("fill count beyond buffer depth");

  a_rev_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REV |-> cnt_q != '0)
    else $error("reverse run with nothing left to send");

  a_done_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_done_o |-> run_last_o)
    else $error("message end not on a run end");

  a_msg_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && message_last_i |=> fill_q == '0 && !dropped_q)
    else $error("buffer state not cleared at message end");

  a_run_last_leaves_rev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_rev && cnt_q == CNT_W'(1) |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after run");

endmodule
